FILE: rtl/tspbb_pkg.sv
// ----------------------------------------------------------------------------
// tspbb_pkg
// Shared types and constants for the branch-and-bound open path search core.
// ----------------------------------------------------------------------------
`default_nettype none

package tspbb_pkg;

  localparam int MAX_NODES_DEF = 20;
  localparam int DIST_BITS_DEF = 16;

  localparam int CITY_W     = 5;
  localparam int DIST_IN_W  = 16;
  localparam int COST_OUT_W = 21;
  localparam int CFG_W      = 5;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_START = 1'b1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_ADD,
    S_EMIT
  } tspbb_state_t;

endpackage

`default_nettype wire

FILE: rtl/tspbb_dist_ram.sv
// ----------------------------------------------------------------------------
// tspbb_dist_ram
// Distance matrix store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tspbb_dist_ram #(
  parameter int AW = 10,
  parameter int DW = 16
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data
);

  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/tsp_branch_and_bound_path_core.sv
// ----------------------------------------------------------------------------
// tsp_branch_and_bound_path_core
// Depth-first branch-and-bound search for the cheapest open path from city 0.
// ----------------------------------------------------------------------------
// Distance write: taken while the core is idle, without stalling the input.
// Start: a scan step per skipped candidate, a scan step (store read) then an add
//   step (shared add and compare) per tried branch, a scan step per backtrack; data dependent.
// Then one result word per city (city_count clamped to 1..MAX_NODES), one per cycle when not stalled.
// Input is stalled from start until the last word is taken.
// Synchronous reset: idle, city_count 1; distance store is not cleared.
`default_nettype none

module tsp_branch_and_bound_path_core #(
  parameter int MAX_NODES = tspbb_pkg::MAX_NODES_DEF,
  parameter int DIST_BITS = tspbb_pkg::DIST_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [tspbb_pkg::CFG_W-1:0]      cfg_city_count,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             in_command,
  input  logic [tspbb_pkg::CITY_W-1:0]     in_to_city,
  input  logic [tspbb_pkg::CITY_W-1:0]     in_from_city,
  input  logic [tspbb_pkg::DIST_IN_W-1:0]  in_distance,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [tspbb_pkg::CITY_W-1:0]     out_position,
  output logic [tspbb_pkg::CITY_W-1:0]     out_city,
  output logic [tspbb_pkg::COST_OUT_W-1:0] out_total_cost,
  output logic                             out_last
);

  import tspbb_pkg::*;

  localparam int CW     = $clog2(MAX_NODES);
  localparam int NW     = $clog2(MAX_NODES + 1);
  localparam int COST_W = DIST_BITS + CW;
  localparam int AW     = 2 * CW;

  tspbb_state_t state_r, state_nxt;

  logic [CFG_W-1:0]     city_count_r;
  logic [NW-1:0]        n_r;
  logic [CW-1:0]        lvl_r;
  logic [NW-1:0]        cand_r;
  logic [MAX_NODES-1:0] visited_r;
  logic                 best_valid_r;
  logic [CW-1:0]        pos_r;

  logic [CW-1:0]        prev_r;
  logic [COST_W-1:0]    cost_r;
  logic [COST_W-1:0]    best_cost_r;
  logic [CW-1:0]        stk_city_r [MAX_NODES];
  logic [CW-1:0]        stk_prev_r [MAX_NODES];
  logic [COST_W-1:0]    stk_cost_r [MAX_NODES];
  logic [CW-1:0]        best_path_r [MAX_NODES];

  logic                 in_acc;
  logic                 out_acc;
  logic                 wr_en;
  logic [NW-1:0]        n_start;
  logic                 scan_done;
  logic [CW-1:0]        cand_idx;
  logic                 cand_seen;
  logic [CW-1:0]        back_idx;
  logic [DIST_BITS-1:0] rd_data;
  logic [COST_W-1:0]    next_cost;
  logic                 take;
  logic                 at_end;
  logic                 top_lvl;
  logic                 emit_end;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_acc   = out_valid && !out_stall;

  assign wr_en = in_acc && (in_command == CMD_WRITE) &&
                 (int'(in_to_city) < MAX_NODES) && (int'(in_from_city) < MAX_NODES);

  always_comb begin
    if (city_count_r == '0) begin
      n_start = NW'(1);
    end else if (int'(city_count_r) > MAX_NODES) begin
      n_start = NW'(MAX_NODES);
    end else begin
      n_start = NW'(city_count_r);
    end
  end

  assign scan_done = (cand_r == n_r);
  assign cand_idx  = cand_r[CW-1:0];
  assign cand_seen = visited_r[cand_idx];
  assign back_idx  = lvl_r - CW'(1);
  assign next_cost = cost_r + COST_W'(rd_data);
  assign take      = !best_valid_r || (next_cost < best_cost_r);
  assign at_end    = (lvl_r == CW'(n_r - NW'(1)));
  assign top_lvl   = (lvl_r == CW'(1));
  assign emit_end  = (pos_r == CW'(n_r - NW'(1)));

  tspbb_dist_ram #(
    .AW(AW),
    .DW(DIST_BITS)
  ) u_dist_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr ({in_to_city[CW-1:0], in_from_city[CW-1:0]}),
    .wr_data (DIST_BITS'(in_distance)),
    .rd_en   ((state_r == S_SCAN) && !scan_done && !cand_seen),
    .rd_addr ({cand_idx, prev_r}),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc && (in_command == CMD_START)) begin
          state_nxt = (n_start == NW'(1)) ? S_EMIT : S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_done) begin
          if (top_lvl) begin
            state_nxt = S_EMIT;
          end
        end else if (!cand_seen) begin
          state_nxt = S_ADD;
        end
      end
      S_ADD: begin
        state_nxt = S_SCAN;
      end
      S_EMIT: begin
        if (out_acc && emit_end) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      city_count_r <= CFG_W'(1);
      n_r          <= NW'(1);
      lvl_r        <= CW'(1);
      cand_r       <= '0;
      visited_r    <= MAX_NODES'(1);
      best_valid_r <= 1'b0;
      pos_r        <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        city_count_r <= cfg_city_count;
      end
      case (state_r)
        S_IDLE: begin
          if (in_acc && (in_command == CMD_START)) begin
            n_r          <= n_start;
            lvl_r        <= CW'(1);
            cand_r       <= '0;
            visited_r    <= MAX_NODES'(1);
            best_valid_r <= (n_start == NW'(1));
            pos_r        <= '0;
          end
        end
        S_SCAN: begin
          if (scan_done) begin
            if (!top_lvl) begin
              lvl_r                          <= back_idx;
              visited_r[stk_city_r[back_idx]] <= 1'b0;
              cand_r                         <= NW'(stk_city_r[back_idx]) + NW'(1);
            end
          end else if (cand_seen) begin
            cand_r <= cand_r + NW'(1);
          end
        end
        S_ADD: begin
          if (take && !at_end) begin
            visited_r[cand_idx] <= 1'b1;
            lvl_r               <= lvl_r + CW'(1);
            cand_r              <= '0;
          end else begin
            cand_r <= cand_r + NW'(1);
          end
          if (take && at_end) begin
            best_valid_r <= 1'b1;
          end
        end
        S_EMIT: begin
          if (out_acc) begin
            pos_r <= pos_r + CW'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  // search payload
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (in_acc && (in_command == CMD_START)) begin
          prev_r         <= '0;
          cost_r         <= '0;
          best_cost_r    <= '0;
          best_path_r[0] <= '0;
        end
      end
      S_SCAN: begin
        if (scan_done && !top_lvl) begin
          prev_r <= stk_prev_r[back_idx];
          cost_r <= stk_cost_r[back_idx];
        end
      end
      S_ADD: begin
        if (take) begin
          if (at_end) begin
            best_cost_r <= next_cost;
            for (int k = 0; k < MAX_NODES; k++) begin
              if (k == 0) begin
                best_path_r[k] <= '0;
              end else if (k == int'(lvl_r)) begin
                best_path_r[k] <= cand_idx;
              end else begin
                best_path_r[k] <= stk_city_r[k];
              end
            end
          end else begin
            stk_city_r[lvl_r] <= cand_idx;
            stk_prev_r[lvl_r] <= prev_r;
            stk_cost_r[lvl_r] <= cost_r;
            prev_r            <= cand_idx;
            cost_r            <= next_cost;
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid      = (state_r == S_EMIT);
  assign out_position   = CITY_W'(pos_r);
  assign out_city       = CITY_W'(best_path_r[pos_r]);
  assign out_total_cost = COST_OUT_W'(best_cost_r);
  assign out_last       = emit_end;

  a_no_accept_while_emit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input taken while result words pending");

  a_origin_visited: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_SCAN) || (state_r == S_ADD)) |-> visited_r[0])
    else $error("city 0 dropped from visited mask");

  a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> ((lvl_r != '0) && (int'(lvl_r) < int'(n_r)) &&
                             (cand_r <= n_r)))
    else $error("search level or candidate out of range");

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_command == CMD_START)) |=> in_stall)
    else $error("start word did not occupy the core");

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_acc && out_last) |=> !out_valid)
    else $error("result word after last");

endmodule

`default_nettype wire

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Loads distance entries into the open path search core and starts searches
// at several city counts. Each emitted path word is checked field by field
// against a local depth-first branch-and-bound search over the same entries,
// or a typed path; the sender and the receiver both idle at random.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import tspbb_pkg::*;

  localparam int NODES        = MAX_NODES_DEF;
  localparam int SETTLE       = 8;
  localparam int RANDOM_ITEMS = 110;
  localparam int NUM_ROWS     = 21;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam longint unsigned NO_ROUTE = 64'hFFFF_FFFF_FFFF_FFFF;

  typedef struct packed {
    logic [CITY_W-1:0]     position;
    logic [CITY_W-1:0]     city;
    logic [COST_OUT_W-1:0] cost;
    logic                  tail;
  } stop_t;

  typedef enum {ROW_WRITE, ROW_START, ROW_CFG} row_op_t;

  typedef struct {
    row_op_t op;
    int      to_c;
    int      from_c;
    int      span;
    int      arg;
    bit      typed;
    int      cost;
  } row_t;

  typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_BEAT} stall_mode_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_W-1:0]      cfg_city_count;
  logic                  in_valid;
  logic                  in_stall;
  logic                  in_command;
  logic [CITY_W-1:0]     in_to_city;
  logic [CITY_W-1:0]     in_from_city;
  logic [DIST_IN_W-1:0]  in_distance;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [CITY_W-1:0]     out_position;
  logic [CITY_W-1:0]     out_city;
  logic [COST_OUT_W-1:0] out_total_cost;
  logic                  out_last;

  logic [DIST_IN_W-1:0] span_tbl [NODES][NODES];
  int                   city_limit = 1;
  stop_t                route_queue [$];
  int                   errors = 0;
  int                   clk_count = 0;
  int                   burst_left = 0;
  bit                   gappy = 1'b1;
  stall_mode_t          stall_mode = STALL_NONE;
  int                   stall_left = 0;

  tsp_branch_and_bound_path_core dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_city_count (cfg_city_count),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_command     (in_command),
    .in_to_city     (in_to_city),
    .in_from_city   (in_from_city),
    .in_distance    (in_distance),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_position   (out_position),
    .out_city       (out_city),
    .out_total_cost (out_total_cost),
    .out_last       (out_last)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  task automatic flag_mismatch(input string what);
    $display("mismatch at cycle %0d: %s", clk_count, what);
    errors++;
  endtask

  // cheapest open path from city 0, lower cities tried first, ties keep the first
  function automatic void plan_route(input int n);
    int                trail [NODES];
    int                best_trail [NODES];
    int                cand [NODES+1];
    longint unsigned   acc [NODES];
    longint unsigned   best;
    longint unsigned   step;
    logic [NODES-1:0]  seen;
    int                lvl;
    int                c;
    stop_t             s;
    best = NO_ROUTE;
    seen = '0;
    seen[0] = 1'b1;
    trail[0] = 0;
    acc[0] = 0;
    lvl = 1;
    cand[1] = 0;
    for (int k = 0; k < NODES; k++) best_trail[k] = 0;
    while (lvl > 0) begin
      if (lvl >= n || cand[lvl] >= n) begin
        if (lvl >= n && acc[lvl-1] < best) begin
          best = acc[lvl-1];
          for (int k = 0; k < n; k++) best_trail[k] = trail[k];
        end
        lvl--;
        if (lvl > 0) seen[trail[lvl]] = 1'b0;
      end else begin
        c = cand[lvl];
        cand[lvl]++;
        if (!seen[c]) begin
          step = acc[lvl-1] + span_tbl[c][trail[lvl-1]];
          if (step < best) begin
            trail[lvl] = c;
            acc[lvl] = step;
            seen[c] = 1'b1;
            lvl++;
            cand[lvl] = 0;
          end
        end
      end
    end
    for (int k = 0; k < n; k++) begin
      s.position = CITY_W'(k);
      s.city     = CITY_W'(best_trail[k]);
      s.cost     = best[COST_OUT_W-1:0];
      s.tail     = (k == n - 1);
      route_queue.push_back(s);
    end
  endfunction

  function automatic int pick_span();
    case ($urandom_range(0, 3))
      0:       return ($urandom_range(0, 1) != 0) ? 65535 : 0;
      1:       return $urandom_range(0, 15);
      default: return $urandom_range(0, 65535);
    endcase
  endfunction

  // one input word; bursts of random length, gaps between them when gappy
  task automatic send_word(input logic cmd, input int to_c, input int from_c,
                           input int span, input bit typed, input int typed_len,
                           input int typed_cost);
    stop_t s;
    if (burst_left == 0) begin
      if (gappy) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
      burst_left = $urandom_range(1, 10);
    end
    burst_left--;
    in_valid     <= 1'b1;
    in_command   <= cmd;
    in_to_city   <= CITY_W'(to_c);
    in_from_city <= CITY_W'(from_c);
    in_distance  <= DIST_IN_W'(span);
    do @(posedge clk); while (in_stall);
    if (cmd == CMD_WRITE) begin
      if (to_c < NODES && from_c < NODES) span_tbl[to_c][from_c] = DIST_IN_W'(span);
    end else if (typed) begin
      for (int k = 0; k < typed_len; k++) begin
        s.position = CITY_W'(k);
        s.city     = CITY_W'(k);
        s.cost     = COST_OUT_W'(typed_cost);
        s.tail     = (k == typed_len - 1);
        route_queue.push_back(s);
      end
    end else begin
      plan_route(city_limit);
    end
  endtask

  // only once the path has drained and trailing writes have settled
  task automatic set_city_count(input int v);
    in_valid <= 1'b0;
    while (route_queue.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    cfg_valid      <= 1'b1;
    cfg_city_count <= CFG_W'(v);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid  <= 1'b0;
    city_limit = (v == 0) ? 1 : (v > NODES) ? NODES : v;
    burst_left = 0;
  endtask

  always @(posedge clk) begin
    stop_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (route_queue.size() == 0) begin
        flag_mismatch($sformatf("unexpected word position %0d city %0d",
                                out_position, out_city));
      end else begin
        want = route_queue.pop_front();
        if (out_position !== want.position)
          flag_mismatch($sformatf("position %0d, want %0d", out_position, want.position));
        if (out_city !== want.city)
          flag_mismatch($sformatf("city %0d at position %0d, want %0d",
                                  out_city, want.position, want.city));
        if (out_total_cost !== want.cost)
          flag_mismatch($sformatf("total_cost %0d at position %0d, want %0d",
                                  out_total_cost, want.position, want.cost));
        if (out_last !== want.tail)
          flag_mismatch($sformatf("last %0b at position %0d, want %0b",
                                  out_last, want.position, want.tail));
      end
    end
  end

  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode = stall_mode_t'($urandom_range(0, 3));
      stall_left = $urandom_range(20, 80);
    end
    stall_left--;
    case (stall_mode)
      STALL_NONE:  out_stall <= 1'b0;
      STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
      default:     out_stall <= clk_count[1] ^ clk_count[3];
    endcase
  end

  always @(posedge clk) begin
    clk_count <= clk_count + 1;
    if (clk_count >= CYCLE_LIMIT) begin
      $display("[tsp_branch_and_bound_path_core] ERROR");
      $finish;
    end
  end

  initial begin
    row_t rows [NUM_ROWS];
    int   counted;
    int   n;
    int   phase_len;
    int   pick;
    int   to_c;
    int   from_c;
    rst_n          = 1'b0;
    cfg_valid      = 1'b0;
    cfg_city_count = '0;
    in_valid       = 1'b0;
    in_command     = CMD_WRITE;
    in_to_city     = '0;
    in_from_city   = '0;
    in_distance    = '0;
    // typed rows: identity path of arg words at the given cost
    rows = '{
      '{ROW_START, 31, 31, 65535, 1, 1'b1, 0},
      '{ROW_CFG,    0,  0,     0, 0, 1'b0, 0},
      '{ROW_START,  0,  0,     0, 1, 1'b1, 0},
      '{ROW_WRITE,  1,  0, 65535, 0, 1'b0, 0},
      '{ROW_WRITE, 31,  0,     0, 0, 1'b0, 0},
      '{ROW_WRITE,  1, 20,     0, 0, 1'b0, 0},
      '{ROW_WRITE, 20, 31,  1234, 0, 1'b0, 0},
      '{ROW_CFG,    0,  0,     0, 2, 1'b0, 0},
      '{ROW_START, 17,  5, 43690, 2, 1'b1, 65535},
      '{ROW_WRITE,  2,  0, 65535, 0, 1'b0, 0},
      '{ROW_WRITE,  2,  1, 65535, 0, 1'b0, 0},
      '{ROW_WRITE,  1,  2, 65535, 0, 1'b0, 0},
      '{ROW_CFG,    0,  0,     0, 3, 1'b0, 0},
      '{ROW_START,  0,  0,     0, 3, 1'b1, 131070},
      '{ROW_WRITE,  1,  0,     5, 0, 1'b0, 0},
      '{ROW_WRITE,  2,  0,     0, 0, 1'b0, 0},
      '{ROW_WRITE,  1,  2,     3, 0, 1'b0, 0},
      '{ROW_WRITE,  2,  1,     3, 0, 1'b0, 0},
      '{ROW_START, 10, 21, 21845, 0, 1'b0, 0},
      '{ROW_WRITE,  1,  0,     0, 0, 1'b0, 0},
      '{ROW_START, 31,  0,     1, 0, 1'b0, 0}
    };
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i]) begin
      case (rows[i].op)
        ROW_CFG:   set_city_count(rows[i].arg);
        ROW_WRITE: send_word(CMD_WRITE, rows[i].to_c, rows[i].from_c, rows[i].span,
                             1'b0, 0, 0);
        default:   send_word(CMD_START, rows[i].to_c, rows[i].from_c, rows[i].span,
                             rows[i].typed, rows[i].arg, rows[i].cost);
      endcase
    end

    // full matrix with a zero-cost chain 0,1,..,19 so the widest search prunes early
    set_city_count(31);
    gappy = ($urandom_range(0, 1) != 0);
    for (int t = 1; t < NODES; t++)
      for (int f = 0; f < NODES; f++)
        if (t != f)
          send_word(CMD_WRITE, t, f, (t == f + 1) ? 0 : $urandom_range(0, 65535),
                    1'b0, 0, 0);
    send_word(CMD_START, $urandom_range(0, 31), $urandom_range(0, 31),
              $urandom_range(0, 65535), 1'b0, 0, 0);
    set_city_count(NODES);
    send_word(CMD_START, $urandom_range(0, 31), $urandom_range(0, 31),
              $urandom_range(0, 65535), 1'b0, 0, 0);

    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      n = $urandom_range(1, 6);
      set_city_count(n);
      gappy = ($urandom_range(0, 3) != 0);
      phase_len = $urandom_range(3, 14);
      for (int j = 0; j < phase_len; j++) begin
        pick = $urandom_range(0, 9);
        if (pick < 6) begin
          to_c   = $urandom_range(0, n - 1);
          from_c = $urandom_range(0, n - 1);
          send_word(CMD_WRITE, to_c, from_c, pick_span(), 1'b0, 0, 0);
          counted++;
        end else if (pick < 8) begin
          to_c   = $urandom_range(0, 31);
          from_c = $urandom_range(0, 31);
          send_word(CMD_WRITE, to_c, from_c, pick_span(), 1'b0, 0, 0);
          if (to_c < NODES && from_c < NODES) counted++;
        end else begin
          send_word(CMD_START, $urandom_range(0, 31), $urandom_range(0, 31),
                    $urandom_range(0, 65535), 1'b0, 0, 0);
          counted++;
        end
      end
      send_word(CMD_START, $urandom_range(0, 31), $urandom_range(0, 31),
                $urandom_range(0, 65535), 1'b0, 0, 0);
      counted++;
    end

    in_valid <= 1'b0;
    while (route_queue.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (errors == 0) begin
      $display("[tsp_branch_and_bound_path_core] OK");
    end else begin
      $display("[tsp_branch_and_bound_path_core] ERROR");
    end
    $finish;
  end

endmodule
